// ===== rtl/mrf_pkg.sv =====
// Shared constants, types and helpers for the marker rectangle finder.
package mrf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int MASK_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int MASK_AW    = $clog2(MASK_DEPTH);
    localparam int COL_AW     = $clog2(MAX_WIDTH);
    localparam int CNT_W      = $clog2(MASK_DEPTH + 1);

    localparam int DIM_W = 11;
    localparam int KEY_W = 8;
    localparam int ST_W  = 2;

    localparam int PIX_W        = 3 * KEY_W;
    localparam int S_TDATA_W    = ((PIX_W + 7) / 8) * 8;
    localparam int RES_W        = ST_W + 4 * DIM_W;
    localparam int M_TDATA_W    = ((RES_W + 7) / 8) * 8;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // scan phases
    localparam logic [1:0] PH_TL   = 2'd0;
    localparam logic [1:0] PH_BR   = 2'd1;
    localparam logic [1:0] PH_FILL = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_FOUND      = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_TL      = 2'd1;
    localparam logic [ST_W-1:0] ST_NO_BR      = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_FILLED = 2'd3;

    typedef struct packed {
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
        logic [DIM_W-1:0] min_run_width;
        logic [DIM_W-1:0] min_run_height;
        logic [KEY_W-1:0] key_blue;
        logic [KEY_W-1:0] key_green;
        logic [KEY_W-1:0] key_red;
    } mrf_cfg_t;

    typedef struct packed {
        logic       pix_take;
        logic       clear;
        logic       init;
        logic [1:0] phase;
        logic       issue;
        logic       out_load;
    } mrf_cmd_t;

    typedef struct packed {
        logic frame_last;
        logic scan_last;
        logic tl_found;
        logic br_found;
        logic rect_ok;
        logic out_busy;
    } mrf_stat_t;

    // zero counts as one, oversize clamps to the maximum
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > lim) begin
            r = lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/marker_rectangle_finder.sv =====
// Sequence: the last pixel of a frame starts a full-frame top-left corner scan (one
//   mask bit per cycle from the mask RAM read port), then a full-frame bottom-right
//   scan if a top-left corner was found, then a fill check over an ordered rectangle.
// Throughput: one pixel per cycle while loading; no pixels are taken during scans
//   or the result hand-off, nor in the cycle after a register write.
// Reset: aresetn synchronous, active low; registers go to their defaults; the mask
//   store is not cleared, as every entry read is written during the frame first.
module marker_rectangle_finder (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mrf_pkg::APB_AW-1:0]    paddr,
    input  logic [mrf_pkg::APB_DW-1:0]    pwdata,
    output logic [mrf_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    // pixel words
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mrf_pkg::S_TDATA_W-1:0] s_tdata,  // pix_blue, pix_green, pix_red
    // result words
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status, left_col, top_row, right_col, bottom_row, zero pad
    output logic [mrf_pkg::M_TDATA_W-1:0] m_tdata
);
    import mrf_pkg::*;

    localparam logic [2:0] REG_FRAME_WIDTH    = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_MIN_RUN_WIDTH  = 3'd2;
    localparam logic [2:0] REG_MIN_RUN_HEIGHT = 3'd3;
    localparam logic [2:0] REG_KEY_BLUE       = 3'd4;
    localparam logic [2:0] REG_KEY_GREEN      = 3'd5;
    localparam logic [2:0] REG_KEY_RED        = 3'd6;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] RST_MIN_RUN      = DIM_W'(100);
    localparam logic [KEY_W-1:0] RST_KEY_BLUE     = KEY_W'(0);
    localparam logic [KEY_W-1:0] RST_KEY_GREEN    = KEY_W'(0);
    localparam logic [KEY_W-1:0] RST_KEY_RED      = KEY_W'(255);

    mrf_cfg_t   cfg_reg;
    logic       cfg_wr;
    logic [2:0] reg_idx;
    logic       cfg_hold_reg;
    mrf_cmd_t   cmd;
    mrf_stat_t  stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width    <= RST_FRAME_WIDTH;
            cfg_reg.frame_height   <= RST_FRAME_HEIGHT;
            cfg_reg.min_run_width  <= RST_MIN_RUN;
            cfg_reg.min_run_height <= RST_MIN_RUN;
            cfg_reg.key_blue       <= RST_KEY_BLUE;
            cfg_reg.key_green      <= RST_KEY_GREEN;
            cfg_reg.key_red        <= RST_KEY_RED;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:    cfg_reg.frame_width    <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT:   cfg_reg.frame_height   <= pwdata[DIM_W-1:0];
                REG_MIN_RUN_WIDTH:  cfg_reg.min_run_width  <= pwdata[DIM_W-1:0];
                REG_MIN_RUN_HEIGHT: cfg_reg.min_run_height <= pwdata[DIM_W-1:0];
                REG_KEY_BLUE:       cfg_reg.key_blue       <= pwdata[KEY_W-1:0];
                REG_KEY_GREEN:      cfg_reg.key_green      <= pwdata[KEY_W-1:0];
                REG_KEY_RED:        cfg_reg.key_red        <= pwdata[KEY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // frame size product is registered; pixels are held in the cycle after a write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_hold_reg <= 1'b1;
        end else begin
            cfg_hold_reg <= cfg_wr;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:    prdata = APB_DW'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT:   prdata = APB_DW'(cfg_reg.frame_height);
            REG_MIN_RUN_WIDTH:  prdata = APB_DW'(cfg_reg.min_run_width);
            REG_MIN_RUN_HEIGHT: prdata = APB_DW'(cfg_reg.min_run_height);
            REG_KEY_BLUE:       prdata = APB_DW'(cfg_reg.key_blue);
            REG_KEY_GREEN:      prdata = APB_DW'(cfg_reg.key_green);
            REG_KEY_RED:        prdata = APB_DW'(cfg_reg.key_red);
            default:            prdata = '0;
        endcase
    end

    mrf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .cfg_hold (cfg_hold_reg),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    mrf_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/mrf_ram.sv =====
// Generic simple dual-port RAM with registered read.
module mrf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/mrf_ctrl.sv =====
// Sequencer: frame load, top-left scan, bottom-right scan, fill check, result.
module mrf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             cfg_hold,
    input  mrf_pkg::mrf_stat_t stat,
    output logic             s_tready,
    output mrf_pkg::mrf_cmd_t  cmd
);
    import mrf_pkg::*;

    localparam logic [3:0] S_LOAD      = 4'd0;
    localparam logic [3:0] S_TL_INIT   = 4'd1;
    localparam logic [3:0] S_TL_RUN    = 4'd2;
    localparam logic [3:0] S_TL_WAIT   = 4'd3;
    localparam logic [3:0] S_BR_INIT   = 4'd4;
    localparam logic [3:0] S_BR_RUN    = 4'd5;
    localparam logic [3:0] S_BR_WAIT   = 4'd6;
    localparam logic [3:0] S_FILL_INIT = 4'd7;
    localparam logic [3:0] S_FILL_RUN  = 4'd8;
    localparam logic [3:0] S_FILL_WAIT = 4'd9;
    localparam logic [3:0] S_OUT       = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_LOAD) && !cfg_hold;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.phase    = PH_TL;
        cmd.pix_take = s_tvalid && s_tready;
        unique case (state_reg)
            S_LOAD: begin
                if (cmd.pix_take && stat.frame_last) begin
                    state_next = S_TL_INIT;
                end
            end
            S_TL_INIT: begin
                cmd.clear  = 1'b1;
                cmd.init   = 1'b1;
                cmd.phase  = PH_TL;
                state_next = S_TL_RUN;
            end
            S_TL_RUN: begin
                cmd.issue = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_TL_WAIT;
                end
            end
            S_TL_WAIT: begin
                state_next = S_BR_INIT;
            end
            S_BR_INIT: begin
                if (stat.tl_found) begin
                    cmd.init   = 1'b1;
                    cmd.phase  = PH_BR;
                    state_next = S_BR_RUN;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_BR_RUN: begin
                cmd.issue = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_BR_WAIT;
                end
            end
            S_BR_WAIT: begin
                state_next = S_FILL_INIT;
            end
            S_FILL_INIT: begin
                if (stat.br_found && stat.rect_ok) begin
                    cmd.init   = 1'b1;
                    cmd.phase  = PH_FILL;
                    state_next = S_FILL_RUN;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_FILL_RUN: begin
                cmd.issue = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_FILL_WAIT;
                end
            end
            S_FILL_WAIT: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/mrf_datapath.sv =====
// Mask store, scan address generator, run evaluation stage and result register.
module mrf_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mrf_pkg::mrf_cfg_t                 cfg,
    input  mrf_pkg::mrf_cmd_t                 cmd,
    output mrf_pkg::mrf_stat_t                stat,
    input  logic [mrf_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mrf_pkg::M_TDATA_W-1:0]     m_tdata
);
    import mrf_pkg::*;

    logic [DIM_W-1:0]   eff_w;
    logic [DIM_W-1:0]   eff_h;
    logic [DIM_W-1:0]   w_m1;
    logic [DIM_W-1:0]   h_m1;
    logic [2*DIM_W-1:0] area;
    logic [CNT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   total_m1;

    logic               is_key;
    logic [CNT_W-1:0]   pix_idx_reg;
    logic [CNT_W-1:0]   pix_idx_next;
    logic [CNT_W-1:0]   cnt_inc;

    // issue stage
    logic [1:0]         ph_reg,        ph_next;
    logic [DIM_W-1:0]   x_reg,         x_next;
    logic [DIM_W-1:0]   y_reg,         y_next;
    logic [MASK_AW-1:0] addr_reg,      addr_next;
    logic [MASK_AW-1:0] row_base_reg,  row_base_next;
    logic               row_start_reg, row_start_next;
    logic               first_row_reg, first_row_next;
    logic               scan_last;

    // evaluation stage
    logic               p_valid_reg;
    logic [1:0]         p_ph_reg;
    logic [DIM_W-1:0]   p_x_reg;
    logic [DIM_W-1:0]   p_y_reg;
    logic [MASK_AW-1:0] p_addr_reg;
    logic               p_row_start_reg;
    logic               p_first_row_reg;

    logic               mask_bit;
    logic [DIM_W-1:0]   col_rd;
    logic               fwd_reg;
    logic [DIM_W-1:0]   fwd_data_reg;
    logic [DIM_W-1:0]   run_reg;
    logic [DIM_W-1:0]   col_old;
    logic [DIM_W-1:0]   run_old;
    logic [DIM_W-1:0]   col_new;
    logic [DIM_W-1:0]   run_new;
    logic               col_we;
    logic               runs_ok;
    logic               tl_hit;
    logic               br_hit;
    logic               fill_miss;

    logic               tl_found_reg;
    logic [DIM_W-1:0]   tl_x_reg;
    logic [DIM_W-1:0]   tl_y_reg;
    logic [MASK_AW-1:0] tl_addr_reg;
    logic               br_found_reg;
    logic [DIM_W-1:0]   br_x_reg;
    logic [DIM_W-1:0]   br_y_reg;
    logic               fill_miss_reg;
    logic               rect_ok;

    logic [ST_W-1:0]    res_status;
    logic [DIM_W-1:0]   res_left;
    logic [DIM_W-1:0]   res_top;
    logic [DIM_W-1:0]   res_right;
    logic [DIM_W-1:0]   res_bottom;
    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // frame geometry
    assign eff_w    = eff_dim(cfg.frame_width, DIM_W'(MAX_WIDTH));
    assign eff_h    = eff_dim(cfg.frame_height, DIM_W'(MAX_HEIGHT));
    assign w_m1     = eff_w - DIM_W'(1);
    assign h_m1     = eff_h - DIM_W'(1);
    assign area     = (2*DIM_W)'(eff_w) * (2*DIM_W)'(eff_h);
    assign total_m1 = total_reg - CNT_W'(1);

    always_ff @(posedge aclk) begin
        total_reg <= area[CNT_W-1:0];
    end

    // frame load
    assign is_key = (s_tdata[KEY_W-1:0]         == cfg.key_blue)  &&
                    (s_tdata[2*KEY_W-1:KEY_W]   == cfg.key_green) &&
                    (s_tdata[3*KEY_W-1:2*KEY_W] == cfg.key_red);

    assign cnt_inc      = pix_idx_reg + CNT_W'(1);
    assign pix_idx_next = (cnt_inc >= total_reg) ? '0 : cnt_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_idx_reg <= '0;
        end else if (cmd.pix_take) begin
            pix_idx_reg <= pix_idx_next;
        end
    end

    mrf_ram #(
        .WIDTH (1),
        .DEPTH (MASK_DEPTH)
    ) u_mask_ram (
        .aclk    (aclk),
        .wr_en   (cmd.pix_take),
        .wr_addr (pix_idx_reg[MASK_AW-1:0]),
        .wr_data (is_key),
        .rd_addr (addr_reg),
        .rd_data (mask_bit)
    );

    // scan address generator
    always_comb begin
        ph_next        = ph_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        addr_next      = addr_reg;
        row_base_next  = row_base_reg;
        row_start_next = row_start_reg;
        first_row_next = first_row_reg;
        if (cmd.init) begin
            ph_next = cmd.phase;
            unique case (cmd.phase)
                PH_TL: begin
                    x_next         = w_m1;
                    y_next         = h_m1;
                    addr_next      = total_m1[MASK_AW-1:0];
                    row_start_next = 1'b1;
                    first_row_next = 1'b1;
                end
                PH_BR: begin
                    x_next         = '0;
                    y_next         = '0;
                    addr_next      = '0;
                    row_start_next = 1'b1;
                    first_row_next = 1'b1;
                end
                PH_FILL: begin
                    x_next        = tl_x_reg;
                    y_next        = tl_y_reg;
                    addr_next     = tl_addr_reg;
                    row_base_next = tl_addr_reg;
                end
                default: begin
                    ph_next = ph_reg;
                end
            endcase
        end else if (cmd.issue) begin
            unique case (ph_reg)
                PH_TL: begin
                    addr_next = addr_reg - MASK_AW'(1);
                    if (x_reg == '0) begin
                        x_next         = w_m1;
                        y_next         = y_reg - DIM_W'(1);
                        row_start_next = 1'b1;
                        first_row_next = 1'b0;
                    end else begin
                        x_next         = x_reg - DIM_W'(1);
                        row_start_next = 1'b0;
                    end
                end
                PH_BR: begin
                    addr_next = addr_reg + MASK_AW'(1);
                    if (x_reg == w_m1) begin
                        x_next         = '0;
                        y_next         = y_reg + DIM_W'(1);
                        row_start_next = 1'b1;
                        first_row_next = 1'b0;
                    end else begin
                        x_next         = x_reg + DIM_W'(1);
                        row_start_next = 1'b0;
                    end
                end
                PH_FILL: begin
                    if (x_reg == br_x_reg) begin
                        x_next        = tl_x_reg;
                        y_next        = y_reg + DIM_W'(1);
                        addr_next     = row_base_reg + MASK_AW'(eff_w);
                        row_base_next = row_base_reg + MASK_AW'(eff_w);
                    end else begin
                        x_next    = x_reg + DIM_W'(1);
                        addr_next = addr_reg + MASK_AW'(1);
                    end
                end
                default: begin
                    x_next = x_reg;
                end
            endcase
        end
    end

    always_comb begin
        unique case (ph_reg)
            PH_TL:   scan_last = (x_reg == '0) && (y_reg == '0);
            PH_BR:   scan_last = (x_reg == w_m1) && (y_reg == h_m1);
            PH_FILL: scan_last = (x_reg == br_x_reg) && (y_reg == br_y_reg);
            default: scan_last = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        ph_reg        <= ph_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        addr_reg      <= addr_next;
        row_base_reg  <= row_base_next;
        row_start_reg <= row_start_next;
        first_row_reg <= first_row_next;
    end

    // evaluation stage, registered from the issue stage in step with the mask RAM read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= cmd.issue;
        end
        p_ph_reg        <= ph_reg;
        p_x_reg         <= x_reg;
        p_y_reg         <= y_reg;
        p_addr_reg      <= addr_reg;
        p_row_start_reg <= row_start_reg;
        p_first_row_reg <= first_row_reg;
    end

    mrf_ram #(
        .WIDTH (DIM_W),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .aclk    (aclk),
        .wr_en   (col_we),
        .wr_addr (p_x_reg[COL_AW-1:0]),
        .wr_data (col_new),
        .rd_addr (x_reg[COL_AW-1:0]),
        .rd_data (col_rd)
    );

    // one-column frames read the entry written in the same cycle
    always_ff @(posedge aclk) begin
        fwd_reg      <= col_we && (x_reg[COL_AW-1:0] == p_x_reg[COL_AW-1:0]);
        fwd_data_reg <= col_new;
        if (p_valid_reg) begin
            run_reg <= run_new;
        end
    end

    assign col_old = p_first_row_reg ? '0 : (fwd_reg ? fwd_data_reg : col_rd);
    assign run_old = p_row_start_reg ? '0 : run_reg;
    assign col_new = mask_bit ? col_old + DIM_W'(1) : '0;
    assign run_new = mask_bit ? run_old + DIM_W'(1) : '0;
    assign col_we  = p_valid_reg && ((p_ph_reg == PH_TL) || (p_ph_reg == PH_BR));

    assign runs_ok = mask_bit && (run_new >= cfg.min_run_width) &&
                     (col_new >= cfg.min_run_height);

    assign tl_hit = p_valid_reg && (p_ph_reg == PH_TL) && runs_ok &&
                    (({1'b0, p_x_reg} + {1'b0, cfg.min_run_width}) < {1'b0, eff_w}) &&
                    (({1'b0, p_y_reg} + {1'b0, cfg.min_run_height}) < {1'b0, eff_h});

    assign br_hit = p_valid_reg && (p_ph_reg == PH_BR) && runs_ok &&
                    (p_x_reg >= cfg.min_run_width) && (p_y_reg >= cfg.min_run_height);

    assign fill_miss = p_valid_reg && (p_ph_reg == PH_FILL) && !mask_bit;

    // later hits overwrite: smallest position for top-left, largest for bottom-right
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            tl_found_reg  <= 1'b0;
            br_found_reg  <= 1'b0;
            fill_miss_reg <= 1'b0;
        end else begin
            if (tl_hit) begin
                tl_found_reg <= 1'b1;
            end
            if (br_hit) begin
                br_found_reg <= 1'b1;
            end
            if (fill_miss) begin
                fill_miss_reg <= 1'b1;
            end
        end
        if (tl_hit) begin
            tl_x_reg    <= p_x_reg;
            tl_y_reg    <= p_y_reg;
            tl_addr_reg <= p_addr_reg;
        end
        if (br_hit) begin
            br_x_reg <= p_x_reg;
            br_y_reg <= p_y_reg;
        end
    end

    assign rect_ok = (tl_x_reg <= br_x_reg) && (tl_y_reg <= br_y_reg);

    // result word
    always_comb begin
        priority if (!tl_found_reg) begin
            res_status = ST_NO_TL;
        end else if (!br_found_reg) begin
            res_status = ST_NO_BR;
        end else if (!rect_ok || fill_miss_reg) begin
            res_status = ST_NOT_FILLED;
        end else begin
            res_status = ST_FOUND;
        end
    end

    assign res_left   = tl_found_reg ? tl_x_reg : '0;
    assign res_top    = tl_found_reg ? tl_y_reg : '0;
    assign res_right  = (tl_found_reg && br_found_reg) ? br_x_reg + DIM_W'(1) : '0;
    assign res_bottom = (tl_found_reg && br_found_reg) ? br_y_reg + DIM_W'(1) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= M_TDATA_W'({res_bottom, res_right, res_top, res_left,
                                       res_status});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign stat.frame_last = cnt_inc >= total_reg;
    assign stat.scan_last  = scan_last;
    assign stat.tl_found   = tl_found_reg;
    assign stat.br_found   = br_found_reg;
    assign stat.rect_ok    = rect_ok;
    assign stat.out_busy   = m_tvalid_reg && !m_tready;

endmodule

// ===== rtl/mrf_checker.sv =====
// Port-level checks for the marker rectangle finder, bound to the top level.
module mrf_port_checks (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mrf_pkg::M_TDATA_W-1:0] m_tdata
);
    import mrf_pkg::*;

    logic [ST_W-1:0]  res_status;
    logic [DIM_W-1:0] res_left;
    logic [DIM_W-1:0] res_top;
    logic [DIM_W-1:0] res_right;
    logic [DIM_W-1:0] res_bottom;

    assign res_status = m_tdata[ST_W-1:0];
    assign res_left   = m_tdata[ST_W+DIM_W-1:ST_W];
    assign res_top    = m_tdata[ST_W+2*DIM_W-1:ST_W+DIM_W];
    assign res_right  = m_tdata[ST_W+3*DIM_W-1:ST_W+2*DIM_W];
    assign res_bottom = m_tdata[ST_W+4*DIM_W-1:ST_W+3*DIM_W];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_no_tl_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res_status == ST_NO_TL) |->
        (res_left == '0) && (res_top == '0) && (res_right == '0) && (res_bottom == '0))
        else $error("no top-left result carries bounds");

    a_no_br_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res_status == ST_NO_BR) |-> (res_right == '0) && (res_bottom == '0))
        else $error("no bottom-right result carries far bounds");

    a_found_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res_status == ST_FOUND) |->
        (res_left < res_right) && (res_top < res_bottom))
        else $error("found rectangle is empty or inverted");

    a_cfg_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite |=> !s_tready)
        else $error("pixel taken in the cycle after a register write");

endmodule

bind marker_rectangle_finder mrf_port_checks u_mrf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
